### rtl/codon_translate_orf_split_macros.svh
// ---------------------------------------------------------------------------
// codon_translate_orf_split_macros.svh
// Assertion macros used by the checker file cts_checker.sv.
// ---------------------------------------------------------------------------
`ifndef CODON_TRANSLATE_ORF_SPLIT_MACROS_SVH
`define CODON_TRANSLATE_ORF_SPLIT_MACROS_SVH

// Check a property while out of reset.
`define CTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cts_pkg.sv
// ---------------------------------------------------------------------------
// cts_pkg
// Constants, types and helpers for the codon translation block.
// ---------------------------------------------------------------------------
package cts_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    localparam int CODON_DEPTH = 64;
    localparam int CODON_IDX_W = 6;
    localparam int ENTRY_W     = 9;

    localparam logic [7:0]  STOP_RESIDUE     = 8'h2A;
    localparam logic [15:0] MIN_LENGTH_RESET = 16'd60;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    localparam logic MODE_NUC   = 1'b0;
    localparam logic MODE_TABLE = 1'b1;

    localparam logic [1:0] PHASE_LAST = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } base_t;

    function automatic base_t base_code(input logic [7:0] c);
        base_t b;
        b.ok = 1'b1;
        case (c)
            CHAR_A:  b.code = 2'd0;
            CHAR_C:  b.code = 2'd1;
            CHAR_G:  b.code = 2'd2;
            CHAR_T:  b.code = 2'd3;
            default: begin
                b.ok   = 1'b0;
                b.code = 2'd0;
            end
        endcase
        return b;
    endfunction

endpackage

### rtl/cts_ram.sv
// ---------------------------------------------------------------------------
// cts_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/codon_translate_orf_split.sv
// ---------------------------------------------------------------------------
// codon_translate_orf_split
// One-frame codon translation with stop-codon segment splitting.
//
//   channel  dir  handshake             payload
//   cfg      in   cfg_wr_en             cfg_wr_data: min_length
//   s_axis   in   tvalid/tready         tdata: symbol, table_index,
//                                       table_residue, table_valid;
//                                       tuser: mode, seq_start
//   m_axis   out  tvalid/tready         tdata: residue, residue_index,
//                                       segment_length, kept_total;
//                                       tlast: segment_end; tuser: keep
//
// One item per cycle while the lookup stage can advance. A result for a codon
// moves in order: accepting its third base loads the registered codon table
// read, then the segment counter update moves it into the output register.
// Reset clears phase, counters, table valid bits and min_length to 60.
// A stalled output holds; input keeps flowing until the lookup stage
// holds a result that cannot move on.
// ---------------------------------------------------------------------------
module codon_translate_orf_split #(
    parameter int LENGTH_BITS = cts_pkg::LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] symbol, [13:8] table_index, [21:14] table_residue,
    // [22] table_valid, [23] zero
    input  logic [23:0] s_axis_tdata,
    // [0] mode, [1] seq_start
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] residue, [23:8] residue_index, [39:24] segment_length,
    // [71:40] kept_total
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // [0] keep
    output logic [0:0]  m_axis_tuser
);

    localparam int EXT_W = 64;

    logic [cts_pkg::CODON_IDX_W-1:0] codon_idx;
    logic [cts_pkg::ENTRY_W-1:0]     entry;

    logic        in_mode, in_start, tab_valid;
    logic [7:0]  sym, tab_residue;
    logic [5:0]  tab_index;
    logic        s_acc, nuc_acc, tab_acc;

    logic [1:0]  phase_reg, phase_next, phase_cur;
    logic [15:0] partial_reg, partial_next, partial_cur;
    cts_pkg::base_t b0, b1, b2;
    logic        lookup;

    logic [cts_pkg::CODON_DEPTH-1:0] written_reg;

    logic        s1_vld_reg, s1_clr_reg, s1_look_reg, s1_wr_reg;
    logic        s1_hit, s1_stop, s1_keep, s1_adv, m_load;
    logic [LENGTH_BITS-1:0] seg_reg, seg_next, seg_cur;
    logic [EXT_W-1:0]       seg_ext;
    logic [31:0] kept_reg, kept_next;
    logic [15:0] min_length_reg;

    logic        m_vld_reg;
    logic [71:0] m_data_reg;
    logic        m_last_reg, m_keep_reg;

    assign in_mode     = s_axis_tuser[0];
    assign in_start    = s_axis_tuser[1];
    assign sym         = s_axis_tdata[7:0];
    assign tab_index   = s_axis_tdata[13:8];
    assign tab_residue = s_axis_tdata[21:14];
    assign tab_valid   = s_axis_tdata[22];

    assign s1_adv        = s1_vld_reg && (!s1_hit || !m_vld_reg || m_axis_tready);
    assign s_axis_tready = !s1_vld_reg || s1_adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign nuc_acc       = s_acc && (in_mode == cts_pkg::MODE_NUC);
    assign tab_acc       = s_acc && (in_mode == cts_pkg::MODE_TABLE);

    always_comb begin
        phase_cur   = in_start ? 2'd0 : phase_reg;
        partial_cur = in_start ? 16'd0 : partial_reg;
        b0 = cts_pkg::base_code(partial_cur[15:8]);
        b1 = cts_pkg::base_code(partial_cur[7:0]);
        b2 = cts_pkg::base_code(sym);
        codon_idx = {b0.code, b1.code, b2.code};
        lookup = 1'b0;
        phase_next   = phase_reg;
        partial_next = partial_reg;
        if (nuc_acc) begin
            if (phase_cur < cts_pkg::PHASE_LAST) begin
                phase_next   = phase_cur + 2'd1;
                partial_next = {partial_cur[7:0], sym};
            end else begin
                phase_next   = 2'd0;
                partial_next = 16'd0;
                lookup       = b0.ok && b1.ok && b2.ok;
            end
        end
    end

    cts_ram #(
        .WIDTH (cts_pkg::ENTRY_W),
        .DEPTH (cts_pkg::CODON_DEPTH)
    ) u_codon_ram (
        .clk   (aclk),
        .we    (tab_acc),
        .waddr (tab_index),
        .wdata ({tab_valid, tab_residue}),
        .re    (lookup),
        .raddr (codon_idx),
        .rdata (entry)
    );

    always_comb begin
        seg_cur = s1_clr_reg ? '0 : seg_reg;
        seg_ext = {{(EXT_W-LENGTH_BITS){1'b0}}, seg_cur};
        s1_hit  = s1_look_reg && s1_wr_reg && entry[8];
        s1_stop = (entry[7:0] == cts_pkg::STOP_RESIDUE);
        s1_keep = seg_ext > {{(EXT_W-16){1'b0}}, min_length_reg};
        m_load  = s1_adv && s1_hit;
        kept_next = kept_reg;
        if (m_load && s1_stop && s1_keep && (kept_reg != '1)) begin
            kept_next = kept_reg + 32'd1;
        end
        seg_next = seg_reg;
        if (s1_adv) begin
            seg_next = seg_cur;
            if (s1_hit) begin
                if (s1_stop) begin
                    seg_next = '0;
                end else if (seg_cur != '1) begin
                    seg_next = seg_cur + LENGTH_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= 2'd0;
            partial_reg    <= 16'd0;
            written_reg    <= '0;
            s1_vld_reg     <= 1'b0;
            seg_reg        <= '0;
            kept_reg       <= 32'd0;
            min_length_reg <= cts_pkg::MIN_LENGTH_RESET;
            m_vld_reg      <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            seg_reg     <= seg_next;
            kept_reg    <= kept_next;
            if (cfg_wr_en) begin
                min_length_reg <= cfg_wr_data;
            end
            if (tab_acc) begin
                written_reg[tab_index] <= 1'b1;
            end
            if (s_acc) begin
                s1_vld_reg <= nuc_acc;
            end else if (s1_adv) begin
                s1_vld_reg <= 1'b0;
            end
            if (m_load) begin
                m_vld_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_clr_reg  <= in_start;
            s1_look_reg <= lookup;
            s1_wr_reg   <= written_reg[codon_idx];
        end
        if (m_load) begin
            m_data_reg[7:0]   <= entry[7:0];
            m_data_reg[23:8]  <= seg_ext[15:0];
            m_data_reg[39:24] <= s1_stop ? seg_ext[15:0] : 16'd0;
            m_data_reg[71:40] <= kept_next;
            m_last_reg        <= s1_stop;
            m_keep_reg        <= s1_stop && s1_keep;
        end
    end

    assign m_axis_tvalid   = m_vld_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tlast    = m_last_reg;
    assign m_axis_tuser[0] = m_keep_reg;

endmodule

### rtl/cts_checker.sv
// ---------------------------------------------------------------------------
// cts_checker
// Port-level checks for codon_translate_orf_split, bound to the top level.
// ---------------------------------------------------------------------------
`include "codon_translate_orf_split_macros.svh"

module cts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    `CTS_ASSERT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `CTS_ASSERT(a_plain, aclk, aresetn, m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == 1'b0 && m_axis_tdata[39:24] == 16'd0 && m_axis_tdata[7:0] != cts_pkg::STOP_RESIDUE, "bad ordinary residue result")
    `CTS_ASSERT(a_stop, aclk, aresetn, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == cts_pkg::STOP_RESIDUE && m_axis_tdata[23:8] == m_axis_tdata[39:24], "bad segment end result")
    `CTS_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind codon_translate_orf_split cts_checker u_cts_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the one-frame codon translator with stop-codon split.
// A short table of directed transactions is followed by random sequences of
// nucleotides, mid-stream codon table rewrites, frame restarts and junk
// bytes under several min_length settings. Two long segments sit on either
// side of the keep threshold. A local predictor tracks the codon table
// and segment state, and every result transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 1_500_000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 220;
    localparam int LONG_CODONS   = 20;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [15:0] LONG_MIN_LEN = 16'd20;

    localparam logic [7:0] RES_LYS   = 8'h4B;
    localparam logic [7:0] RES_PHE   = 8'h46;
    localparam logic [5:0] CODON_AAA = 6'd0;
    localparam logic [5:0] CODON_AAC = 6'd1;
    localparam logic [5:0] CODON_TAA = 6'd48;
    localparam logic [5:0] CODON_TTT = 6'd63;

    typedef struct packed {
        logic       mode;
        logic       seq_start;
        logic [7:0] symbol;
        logic [5:0] tidx;
        logic [7:0] tres;
        logic       tval;
    } nuc_item_t;

    typedef struct packed {
        logic [7:0]  residue;
        logic [15:0] res_idx;
        logic        seg_end;
        logic        keep;
        logic [15:0] seg_len;
        logic [31:0] kept_total;
    } orf_result_t;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_kind_t;

    typedef struct {
        nuc_item_t   it;
        chk_kind_t   chk;
        orf_result_t want;
    } dir_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;

    codon_translate_orf_split dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // predictor state
    logic [15:0] min_len    = cts_pkg::MIN_LENGTH_RESET;
    logic [1:0]  frame_phase = '0;
    logic [15:0] held_bases = '0;
    logic [8:0]  codon_map [cts_pkg::CODON_DEPTH];
    logic [15:0] seg_len    = '0;
    logic [31:0] kept_cnt   = '0;

    orf_result_t residue_q [$];
    dir_row_t    dir_tab [$];
    int          mismatches = 0;
    int          tx_prof    = 2;
    int          rx_prof    = 1;
    int          rx_hold    = 0;

    initial begin
        foreach (codon_map[i]) codon_map[i] = '0;
    end

    function automatic int base_of(input logic [7:0] c);
        case (c)
            cts_pkg::CHAR_A: return 0;
            cts_pkg::CHAR_C: return 1;
            cts_pkg::CHAR_G: return 2;
            cts_pkg::CHAR_T: return 3;
            default:         return -1;
        endcase
    endfunction

    function automatic bit orf_predict(input nuc_item_t it, output orf_result_t r);
        int         b0;
        int         b1;
        int         b2;
        logic [8:0] ent;
        r = '0;
        if (it.mode == cts_pkg::MODE_TABLE) begin
            codon_map[it.tidx] = {it.tval, it.tres};
            return 1'b0;
        end
        if (it.seq_start) begin
            frame_phase = '0;
            held_bases  = '0;
            seg_len     = '0;
        end
        if (frame_phase < cts_pkg::PHASE_LAST) begin
            held_bases  = {held_bases[7:0], it.symbol};
            frame_phase = frame_phase + 2'd1;
            return 1'b0;
        end
        frame_phase = '0;
        b0 = base_of(held_bases[15:8]);
        b1 = base_of(held_bases[7:0]);
        b2 = base_of(it.symbol);
        held_bases = '0;
        if (b0 < 0 || b1 < 0 || b2 < 0) return 1'b0;
        ent = codon_map[{b0[1:0], b1[1:0], b2[1:0]}];
        if (!ent[8]) return 1'b0;
        r.residue    = ent[7:0];
        r.res_idx    = seg_len;
        r.kept_total = kept_cnt;
        if (ent[7:0] == cts_pkg::STOP_RESIDUE) begin
            r.seg_end = 1'b1;
            r.keep    = seg_len > min_len;
            if (r.keep && kept_cnt != '1) kept_cnt = kept_cnt + 32'd1;
            r.seg_len    = seg_len;
            r.kept_total = kept_cnt;
            seg_len      = '0;
        end else if (seg_len != '1) begin
            seg_len = seg_len + 16'd1;
        end
        return 1'b1;
    endfunction

    function automatic void queue_result(input orf_result_t r);
        residue_q.insert(residue_q.size(), r);
    endfunction

    function automatic int draw_gap(input int prof);
        case (prof)
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
            default: return int'($urandom_range(0, 16));
        endcase
    endfunction

    function automatic nuc_item_t nuc(input logic start, input logic [7:0] sym);
        nuc_item_t it;
        it           = '0;
        it.mode      = cts_pkg::MODE_NUC;
        it.seq_start = start;
        it.symbol    = sym;
        return it;
    endfunction

    function automatic nuc_item_t tbl(input logic [5:0] idx, input logic [7:0] res,
                                      input logic val);
        nuc_item_t it;
        it      = '0;
        it.mode = cts_pkg::MODE_TABLE;
        it.tidx = idx;
        it.tres = res;
        it.tval = val;
        return it;
    endfunction

    function automatic orf_result_t orf_res(input logic [7:0] res, input logic [15:0] idx,
                                            input logic send, input logic kp,
                                            input logic [15:0] len, input logic [31:0] kept);
        orf_result_t r;
        r.residue    = res;
        r.res_idx    = idx;
        r.seg_end    = send;
        r.keep       = kp;
        r.seg_len    = len;
        r.kept_total = kept;
        return r;
    endfunction

    function automatic void add_row(input nuc_item_t it, input chk_kind_t chk,
                                    input orf_result_t want);
        dir_row_t d;
        d.it   = it;
        d.chk  = chk;
        d.want = want;
        dir_tab.insert(dir_tab.size(), d);
    endfunction

    function automatic logic [7:0] rand_base();
        case ($urandom_range(0, 3))
            0:       return cts_pkg::CHAR_A;
            1:       return cts_pkg::CHAR_C;
            2:       return cts_pkg::CHAR_G;
            default: return cts_pkg::CHAR_T;
        endcase
    endfunction

    function automatic nuc_item_t rand_table_write(input logic [5:0] idx);
        nuc_item_t it;
        it           = '0;
        it.mode      = cts_pkg::MODE_TABLE;
        it.seq_start = 1'($urandom_range(0, 1));
        it.symbol    = 8'($urandom_range(0, 255));
        it.tidx      = idx;
        it.tres      = ($urandom_range(0, 7) == 0) ? cts_pkg::STOP_RESIDUE
                                                   : 8'($urandom_range(0, 255));
        it.tval      = ($urandom_range(0, 9) != 0);
        return it;
    endfunction

    function automatic nuc_item_t rand_item();
        nuc_item_t it;
        int        pick;
        pick         = int'($urandom_range(0, 99));
        it.mode      = cts_pkg::MODE_NUC;
        it.seq_start = 1'b0;
        it.symbol    = rand_base();
        it.tidx      = 6'($urandom_range(0, 63));
        it.tres      = 8'($urandom_range(0, 255));
        it.tval      = 1'($urandom_range(0, 1));
        if (pick < 3) begin
            it = rand_table_write(6'($urandom_range(0, 63)));
        end else if (pick < 7) begin
            it.seq_start = 1'b1;
        end else if (pick < 13) begin
            it.symbol = 8'($urandom_range(0, 255));
        end
        return it;
    endfunction

    task automatic send_item(input nuc_item_t it, output bit hit, output orf_result_t r);
        int gap;
        gap = draw_gap(tx_prof);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.tval, it.tres, it.tidx, it.symbol};
        s_axis_tuser  <= {it.seq_start, it.mode};
        do @(posedge aclk); while (!s_axis_tready);
        hit = orf_predict(it, r);
    endtask

    task automatic push_item(input nuc_item_t it);
        bit          hit;
        orf_result_t r;
        send_item(it, hit, r);
        if (hit) queue_result(r);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        while (residue_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_min_len(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        min_len = v;
    endtask

    task automatic run_random(input int n, input logic [15:0] ml, input bit pressure);
        int i;
        go_idle();
        write_min_len(ml);
        for (i = 0; i < cts_pkg::CODON_DEPTH; i++) push_item(rand_table_write(6'(i)));
        if (pressure) begin
            tx_prof = 0;
            rx_hold = HOLD_CYCLES;
        end
        for (i = 0; i < n; i++) begin
            if (i % 40 == 0 && !(pressure && i < 160)) begin
                tx_prof = int'($urandom_range(0, 2));
                rx_prof = int'($urandom_range(0, 2));
            end
            push_item(rand_item());
        end
    endtask

    task automatic run_long_segments();
        int i;
        int n;
        go_idle();
        write_min_len(LONG_MIN_LEN);
        tx_prof = 0;
        rx_prof = 0;
        push_item(tbl(CODON_AAA, RES_LYS, 1'b1));
        push_item(tbl(CODON_TAA, cts_pkg::STOP_RESIDUE, 1'b1));
        for (n = LONG_CODONS; n <= LONG_CODONS + 1; n++) begin
            for (i = 0; i < n; i++) begin
                push_item(nuc((i == 0) && (n == LONG_CODONS), cts_pkg::CHAR_A));
                push_item(nuc(1'b0, cts_pkg::CHAR_A));
                push_item(nuc(1'b0, cts_pkg::CHAR_A));
            end
            push_item(nuc(1'b0, cts_pkg::CHAR_T));
            push_item(nuc(1'b0, cts_pkg::CHAR_A));
            push_item(nuc(1'b0, cts_pkg::CHAR_A));
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            mismatches++;
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endtask

    initial begin
        int          stall;
        orf_result_t want;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = (rx_hold > 0) ? rx_hold : draw_gap(rx_prof);
            rx_hold = 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            if (residue_q.size() == 0) begin
                mismatches++;
                $error("result transaction with nothing expected: tdata 0x%0h",
                       m_axis_tdata);
            end else begin
                want = residue_q.pop_front();
                check_field("residue", 64'(want.residue), 64'(m_axis_tdata[7:0]));
                check_field("residue_index", 64'(want.res_idx), 64'(m_axis_tdata[23:8]));
                check_field("segment_end", 64'(want.seg_end), 64'(m_axis_tlast));
                check_field("keep", 64'(want.keep), 64'(m_axis_tuser[0]));
                check_field("segment_length", 64'(want.seg_len), 64'(m_axis_tdata[39:24]));
                check_field("kept_total", 64'(want.kept_total), 64'(m_axis_tdata[71:40]));
            end
        end
    end

    initial begin
        int cyc;
        cyc = 0;
        while (cyc < LIMIT_CYCLES) begin
            @(posedge aclk);
            cyc++;
        end
        $display("codon_translate_orf_split verification failed");
        $finish;
    end

    initial begin
        orf_result_t none_r;
        bit          hit;
        orf_result_t r;
        none_r = '0;

        // empty table: a full codon yields nothing
        add_row(nuc(1'b1, cts_pkg::CHAR_A), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_A), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_A), CHK_NONE, none_r);
        add_row(tbl(CODON_AAA, RES_LYS, 1'b1), CHK_NONE, none_r);
        add_row(tbl(CODON_TTT, RES_PHE, 1'b1), CHK_NONE, none_r);
        add_row(tbl(CODON_TAA, cts_pkg::STOP_RESIDUE, 1'b1), CHK_NONE, none_r);
        add_row(tbl(CODON_AAC, 8'hFF, 1'b0), CHK_NONE, none_r);
        add_row(nuc(1'b1, cts_pkg::CHAR_A), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_A), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_A), CHK_TYPED,
                orf_res(RES_LYS, 16'd0, 1'b0, 1'b0, 16'd0, 32'd0));
        add_row(nuc(1'b0, cts_pkg::CHAR_T), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_T), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_T), CHK_TYPED,
                orf_res(RES_PHE, 16'd1, 1'b0, 1'b0, 16'd0, 32'd0));
        // invalid entry, then a bad base
        add_row(nuc(1'b0, cts_pkg::CHAR_A), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_A), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_C), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_A), CHK_NONE, none_r);
        add_row(nuc(1'b0, 8'h00), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_A), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_T), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_A), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_A), CHK_TYPED,
                orf_res(cts_pkg::STOP_RESIDUE, 16'd2, 1'b1, 1'b0, 16'd2, 32'd0));
        // restart in mid codon drops the held base
        add_row(nuc(1'b0, cts_pkg::CHAR_T), CHK_NONE, none_r);
        add_row(nuc(1'b1, cts_pkg::CHAR_T), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_T), CHK_NONE, none_r);
        add_row(nuc(1'b0, cts_pkg::CHAR_T), CHK_MODEL, none_r);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        tx_prof = 2;
        rx_prof = 2;
        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].it, hit, r);
            case (dir_tab[i].chk)
                CHK_MODEL: begin
                    if (hit) queue_result(r);
                end
                CHK_TYPED: begin
                    queue_result(dir_tab[i].want);
                end
                default: begin
                end
            endcase
        end

        run_random(RANDOM_ITEMS, 16'd0, 1'b1);
        run_random(RANDOM_ITEMS, 16'hFFFF, 1'b0);
        run_random(RANDOM_ITEMS, 16'd7, 1'b0);
        run_long_segments();
        run_random(RANDOM_ITEMS, 16'($urandom_range(0, 16)), 1'b0);
        run_random(RANDOM_ITEMS, 16'd3, 1'b0);
        go_idle();

        if (mismatches == 0 && residue_q.size() == 0) begin
            $display("codon_translate_orf_split verification clean");
        end else begin
            $display("codon_translate_orf_split verification failed");
        end
        $finish;
    end

endmodule
